// File: rtl/linear_probe_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Shared concurrent assertion forms for the hash table RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash table assertion failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash table assertion failed (next cycle)");

`endif

// File: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Table geometry, word codes and helper functions shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int KEY_BITS   = 16;
  localparam int SLOT_BITS  = $clog2(TABLE_SIZE);

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [KEY_BITS-1:0]  key_t;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  localparam slot_t SLOT_LAST = SLOT_BITS'(TABLE_SIZE - 1);

  // Control of the used-bit vector from the sequencer.
  typedef struct packed {
    logic  clear;
    logic  set;
    slot_t idx;
  } used_ctl_t;

  function automatic slot_t next_slot(input slot_t s);
    next_slot = (s == SLOT_LAST) ? '0 : s + slot_t'(1);
  endfunction

endpackage

// File: rtl/lpht_key_ram.sv
// ----------------------------------------------------------------------------
// Key store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_key_ram (
  input  logic          clk,
  input  logic          we,
  input  lpht_pkg::slot_t waddr,
  input  lpht_pkg::key_t  wdata,
  input  lpht_pkg::slot_t raddr,
  output lpht_pkg::key_t  rdata
);
  import lpht_pkg::*;

  key_t mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lpht_used_bits.sv
// ----------------------------------------------------------------------------
// Slot used bits
// One flag per slot, cleared by reset or by a clear word, set on insert.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_used_bits (
  input  logic                               clk,
  input  logic                               rst,
  input  lpht_pkg::used_ctl_t                ctl,
  output logic [lpht_pkg::TABLE_SIZE-1:0]    used
);
  import lpht_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      used <= '0;
    end else if (ctl.set) begin
      used[ctl.idx] <= 1'b1;
    end
  end

endmodule

// File: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Linear probe hash table
// Insert, search and clear of 16-bit keys in an open-addressed table.
// ----------------------------------------------------------------------------
// Each input word is handled on its own. An insert or search is accepted,
// then probes one slot per cycle (up to TABLE_SIZE slots, set by the single
// read port of the key store), then loads the result register once it is
// free. A clear or an unused action code goes from acceptance straight to
// loading the result register. The used flags are cleared at once by reset
// or a clear word, so no clearing pass runs. A new word is accepted while
// the previous result still waits on stall.
`timescale 1ns / 1ps

`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  slot
);
  import lpht_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    CHECK,
    RESP
  } state_t;

  state_t     state;
  logic [1:0] act;
  key_t       key_q;
  slot_t      s;
  slot_t      cnt;
  logic [2:0] pend_status;
  slot_t      pend_slot;

  logic [TABLE_SIZE-1:0] used;
  used_ctl_t             used_ctl;
  key_t                  rdata;
  slot_t                 probe_next;
  key_t                  key_in;
  logic                  in_acc;
  logic                  out_free;
  logic                  hit_empty;
  logic                  hit_key;
  logic                  done;
  logic [2:0]            res_status;
  logic                  ram_we;

  assign key_in   = key[KEY_BITS-1:0];
  assign in_stall = (state != IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // The key store is read at probe_next, the address that s also takes, so rdata
  // always belongs to the slot currently being checked.
  assign hit_empty = !used[s];
  assign hit_key   = (act == ACT_SEARCH) && (rdata == key_q);
  assign done      = hit_empty || hit_key || (cnt == SLOT_LAST);

  always_comb begin
    if (hit_empty) begin
      res_status = (act == ACT_INSERT) ? ST_INSERTED : ST_MISSING;
    end else if (hit_key) begin
      res_status = ST_FOUND;
    end else begin
      res_status = (act == ACT_INSERT) ? ST_FULL : ST_MISSING;
    end
  end

  always_comb begin
    case (state)
      IDLE:    probe_next = SLOT_BITS'(key_in % TABLE_SIZE);
      CHECK:   probe_next = done ? s : next_slot(s);
      default: probe_next = s;
    endcase
  end

  assign ram_we = (state == CHECK) && (act == ACT_INSERT) && hit_empty;

  always_comb begin
    used_ctl.clear = in_acc && (action == ACT_CLEAR);
    used_ctl.set   = ram_we;
    used_ctl.idx   = s;
  end

  lpht_key_ram u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s),
    .wdata (key_q),
    .raddr (probe_next),
    .rdata (rdata)
  );

  lpht_used_bits u_used_bits (
    .clk  (clk),
    .rst  (rst),
    .ctl  (used_ctl),
    .used (used)
  );

  always_ff @(posedge clk) begin
    s <= probe_next;
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // In RESP the result register is reloaded below whenever it is free.
      if (out_valid && !out_stall && (state != RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_acc) begin
            act   <= action;
            key_q <= key_in;
            cnt   <= '0;
            case (action)
              ACT_INSERT, ACT_SEARCH: begin
                state <= CHECK;
              end
              ACT_CLEAR: begin
                pend_status <= ST_CLEARED;
                pend_slot   <= '0;
                state       <= RESP;
              end
              default: begin
                pend_status <= ST_MISSING;
                pend_slot   <= '0;
                state       <= RESP;
              end
            endcase
          end
        end
        CHECK: begin
          if (done) begin
            pend_status <= res_status;
            pend_slot   <= s;
            state       <= RESP;
          end else begin
            cnt <= cnt + slot_t'(1);
          end
        end
        RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= pend_status;
            slot      <= 4'(pend_slot);
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A clear word empties every slot by the next cycle.
  `LPHT_ASSERT_NEXT(a_clear_empties, clk, rst, in_acc && (action == ACT_CLEAR), used == '0)
  // A full report is only issued when every slot is in use.
  `LPHT_ASSERT_SAME(a_full_all_used, clk, rst, (state == RESP) && out_free && (pend_status == ST_FULL), &used)
  // An insert never writes over a slot that is already in use.
  `LPHT_ASSERT_SAME(a_no_overwrite, clk, rst, ram_we, !used[s])

endmodule

// File: tb/linear_probe_hash_table_tb.sv
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives insert, search, clear and spare words with random gaps and output stalls,
// predicts every reply from a private copy of the table and checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;

  import lpht_pkg::*;

  // The block answers this spare action code with a plain miss.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int WORD_TARGET = 950;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [1:0]  act;
    key_t        key;
    int unsigned gap;
  } table_word_t;

  typedef struct packed {
    logic [2:0] status;
    slot_t      slot;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_CLEAR;
  logic [15:0] key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [3:0]  slot;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  bit          sender_eager = 1'b0;
  bit          receiver_eager = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_left = 0;
  int unsigned words_queued = 0;
  int unsigned mismatches = 0;

  table_word_t  pending_q[$];
  table_reply_t replies_q[$];

  key_t bucket_key  [TABLE_SIZE];
  logic bucket_used [TABLE_SIZE];

  linear_probe_hash_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .slot      (slot)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    foreach (bucket_used[i]) begin
      bucket_used[i] = 1'b0;
      bucket_key[i]  = '0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;
  end

  // Applies one word to the shadow table and returns the reply it must give.
  function automatic table_reply_t apply_word(input logic [1:0] act, input key_t k);
    table_reply_t r;
    slot_t        probe;
    slot_t        last;
    bit           done;
    probe    = slot_t'(k % TABLE_SIZE);
    last     = probe;
    done     = 1'b0;
    r.status = ST_MISSING;
    r.slot   = '0;
    case (act)
      ACT_CLEAR: begin
        foreach (bucket_used[i]) bucket_used[i] = 1'b0;
        r.status = ST_CLEARED;
      end
      ACT_INSERT: begin
        r.status = ST_FULL;
        for (int n = 0; n < TABLE_SIZE && !done; n++) begin
          if (!bucket_used[probe]) begin
            bucket_key[probe]  = k;
            bucket_used[probe] = 1'b1;
            r.status = ST_INSERTED;
            r.slot   = probe;
            done     = 1'b1;
          end else begin
            last  = probe;
            probe = (probe == slot_t'(TABLE_SIZE - 1)) ? '0 : probe + slot_t'(1);
          end
        end
        if (!done) r.slot = last;
      end
      ACT_SEARCH: begin
        for (int n = 0; n < TABLE_SIZE && !done; n++) begin
          if (!bucket_used[probe]) begin
            r.slot = probe;
            done   = 1'b1;
          end else if (bucket_key[probe] == k) begin
            r.status = ST_FOUND;
            r.slot   = probe;
            done     = 1'b1;
          end else begin
            last  = probe;
            probe = (probe == slot_t'(TABLE_SIZE - 1)) ? '0 : probe + slot_t'(1);
          end
        end
        if (!done) r.slot = last;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Input words are presented at the falling edge; each carries the idle gap
  // that follows it.
  always @(negedge clk) begin : drive_words
    table_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else if (!in_valid || in_fire) begin
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left--;
      end else if (pending_q.size() > 0) begin
        w = pending_q.pop_front();
        action   <= w.act;
        key      <= w.key;
        in_valid <= 1'b1;
        idle_left = w.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side: a stall drawn after every reply, plus long hold-offs on request.
  always @(negedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (out_fire) stall_left = receiver_eager ? 0 : $urandom_range(0, 19);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Predictions are queued before replies are retired, so a word accepted in
  // the same cycle as a reply never disturbs the ordering.
  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall) replies_q.push_back(apply_word(action, key));
      if (out_valid && !out_stall) begin
        if (replies_q.size() == 0) begin
          $error("unexpected reply: status %0d slot %0d", status, slot);
          mismatches++;
        end else begin
          want = replies_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic int unsigned draw_gap();
    return sender_eager ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic add_word(input logic [1:0] act, input key_t k);
    table_word_t w;
    w.act = act;
    w.key = k;
    w.gap = draw_gap();
    pending_q.push_back(w);
    words_queued++;
  endtask

  // Holds the sender back until every outstanding reply has been retired.
  // The check runs at the rising edge, where the driven inputs are settled.
  task automatic settle();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || replies_q.size() != 0);
  endtask

  initial begin : stimulus
    key_t        pool [8];
    key_t        base;
    key_t        k;
    logic [1:0]  act;
    int unsigned pool_n;
    int unsigned n_words;
    int unsigned p_insert;
    int unsigned roll;
    int unsigned episode;

    // Directed: empty table, the spare code, collisions, duplicates, wrap,
    // a full table and a miss that visits every slot.
    add_word(ACT_CLEAR, 16'h5A5A);
    add_word(ACT_SEARCH, 16'h1234);
    add_word(ACT_SPARE, 16'hFFFF);
    add_word(ACT_INSERT, 16'h0000);
    add_word(ACT_INSERT, 16'hFFFF);
    add_word(ACT_INSERT, 16'h0010);
    add_word(ACT_INSERT, 16'h0000);
    add_word(ACT_SEARCH, 16'h0010);
    add_word(ACT_SEARCH, 16'h0020);
    add_word(ACT_SEARCH, 16'hFFFF);
    for (int s = 3; s <= 14; s++) add_word(ACT_INSERT, 16'hA5A0 + key_t'(s));
    add_word(ACT_INSERT, 16'h8001);
    add_word(ACT_SEARCH, 16'h7777);
    add_word(ACT_CLEAR, 16'h0000);
    settle();

    episode = 0;
    while (words_queued < WORD_TARGET) begin
      episode++;
      sender_eager   = ($urandom_range(0, 4) == 0);
      receiver_eager = ($urandom_range(0, 4) == 0);

      // Long receiver hold-off while words keep coming back to back.
      if (episode == 3) begin
        settle();
        sender_eager = 1'b1;
        hold_asked++;
        for (int i = 0; i < 14; i++)
          add_word($urandom_range(0, 1) ? ACT_INSERT : ACT_SEARCH, key_t'($urandom));
        settle();
        sender_eager = 1'b0;
      end

      if ($urandom_range(0, 9) != 0) add_word(ACT_CLEAR, key_t'($urandom));

      // Keys clustered round a few home slots give long probe chains.
      base   = key_t'($urandom);
      pool_n = $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++) begin
        pool[i] = key_t'($urandom);
        if ($urandom_range(0, 1)) pool[i][3:0] = base[3:0] + 4'($urandom_range(0, 3));
      end

      n_words  = $urandom_range(8, 40);
      p_insert = $urandom_range(25, 75);
      for (int j = 0; j < n_words; j++) begin
        roll = $urandom_range(0, 99);
        k = ($urandom_range(0, 3) == 0) ? key_t'($urandom) : pool[$urandom_range(0, pool_n - 1)];
        if (roll < 3)                 act = ACT_CLEAR;
        else if (roll < 6)            act = ACT_SPARE;
        else if (roll < 6 + p_insert) act = ACT_INSERT;
        else                          act = ACT_SEARCH;
        add_word(act, k);
      end

      if ($urandom_range(0, 3) == 0) settle();
    end

    settle();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
